/* rtl/rac_pkg.sv */
// ----------------------------------------------------------------------------
// rac_pkg
// Shared types, codes and the saturating helper for the amplitude converter.
// ----------------------------------------------------------------------------
package rac_pkg;

  localparam int unsigned DataW = 32;

  localparam logic MODE_INTENSITY = 1'b0;
  localparam logic MODE_ANOMALOUS = 1'b1;

  typedef struct packed {
    logic signed [DataW-1:0] value_plus;
    logic signed [DataW-1:0] sigma_plus;
    logic signed [DataW-1:0] value_minus;
    logic signed [DataW-1:0] sigma_minus;
  } rac_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] amp_plus;
    logic signed [DataW-1:0] amp_sigma_plus;
    logic signed [DataW-1:0] amp_minus;
    logic signed [DataW-1:0] amp_sigma_minus;
    logic                    saturated;
  } rac_out_t;

  // result of one lane, handed to the merge register
  typedef struct packed {
    logic signed [DataW-1:0] amp;
    logic signed [DataW-1:0] amp_sigma;
    logic                    clip;
  } rac_lane_res_t;

  typedef struct packed {
    logic signed [DataW-1:0] val;
    logic                    clip;
  } rac_sat_t;

  // clip a 34-bit exact sum to the 32-bit range
  function automatic rac_sat_t rac_sat(input logic signed [DataW+1:0] v);
    rac_sat_t r;
    logic     hi_ok;
    hi_ok = (v[DataW+1:DataW-1] == 3'b000) || (v[DataW+1:DataW-1] == 3'b111);
    r.clip = ~hi_ok;
    if (hi_ok) begin
      r.val = v[DataW-1:0];
    end else if (v[DataW+1]) begin
      r.val = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      r.val = {1'b0, {(DataW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

/* rtl/rac_sqrt.sv */
// ----------------------------------------------------------------------------
// rac_sqrt
// Pipelined floor square root, one root bit resolved per stage.
// ----------------------------------------------------------------------------
module rac_sqrt #(
  parameter int unsigned RadW = 40
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [RadW-1:0]     rad_i,
  output logic [RadW/2-1:0]   root_o
);
  localparam int unsigned QW  = RadW / 2;
  localparam int unsigned RmW = QW + 2;

  logic [RmW-1:0]  rem_q  [QW];
  logic [QW-1:0]   root_q [QW];
  logic [RadW-1:0] x_q    [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [RmW-1:0]  rem_in;
    logic [QW-1:0]   root_in;
    logic [RadW-1:0] x_in;
    logic [RmW-1:0]  rem_sh;
    logic [RmW-1:0]  trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign x_in    = x_q[k-1];
    end

    assign rem_sh = {rem_in[RmW-3:0], x_in[RadW-1:RadW-2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_in[QW-2:0], ge};
        x_q[k]    <= {x_in[RadW-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[QW-1];

endmodule

/* rtl/rac_lane.sv */
// ----------------------------------------------------------------------------
// rac_lane
// One pair of the item: operand prep, two square roots, result select.
// ----------------------------------------------------------------------------
module rac_lane #(
  parameter int unsigned FracBits = 8,
  parameter bit          IsMinus  = 1'b0
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic                          mode_i,
  input  logic signed [31:0]            own_val_i,
  input  logic signed [31:0]            own_sig_i,
  input  logic signed [31:0]            f_i,
  input  logic signed [31:0]            sf_i,
  input  logic signed [31:0]            d_i,
  input  logic signed [31:0]            sd_i,
  output rac_pkg::rac_lane_res_t        res_o
);
  import rac_pkg::*;

  localparam int unsigned RawW = DataW + FracBits;
  localparam int unsigned RadW = RawW + (RawW % 2);
  localparam int unsigned QW   = RadW / 2;

  typedef struct packed {
    logic                    conv;
    logic                    mode;
    logic                    sum_pos;
    logic signed [DataW-1:0] val0;
    logic signed [DataW-1:0] val1;
    logic                    clip;
  } side_t;

  logic              conv, v_pos;
  logic [DataW:0]    neg_v;
  logic [DataW-1:0]  mag;
  rac_sat_t          sp_sat, sum_sat, a_sat, s_sat;
  logic signed [DataW-1:0] sp, h, hs;
  logic signed [DataW+1:0] a_ext;
  side_t             side_d;
  logic [RadW-1:0]   rad_f_d, rad_s_d, rad_f_q, rad_s_q;
  side_t             side_q [QW+1];
  logic [QW-1:0]     root_f, root_s;
  side_t             side_o;

  always_comb begin
    conv  = own_sig_i > 0;
    v_pos = own_val_i > 0;
    neg_v = -{own_val_i[DataW-1], own_val_i};
    mag   = v_pos ? own_val_i[DataW-1:0] : neg_v[DataW-1:0];
    // sigma' = sigma - 2*I on the non-positive path
    sp_sat = rac_sat({{2{own_sig_i[DataW-1]}}, own_sig_i}
                     - {own_val_i[DataW-1], own_val_i, 1'b0});
    sp = v_pos ? own_sig_i : sp_sat.val;
    sum_sat = rac_sat({{2{own_val_i[DataW-1]}}, own_val_i} + {{2{sp[DataW-1]}}, sp});

    // halving is an arithmetic shift
    h  = {d_i[DataW-1], d_i[DataW-1:1]};
    hs = {sd_i[DataW-1], sd_i[DataW-1:1]};
    if (IsMinus) begin
      a_ext = {{2{f_i[DataW-1]}}, f_i} - {{2{h[DataW-1]}}, h};
    end else begin
      a_ext = {{2{f_i[DataW-1]}}, f_i} + {{2{h[DataW-1]}}, h};
    end
    a_sat = rac_sat(a_ext);
    s_sat = rac_sat({{2{sf_i[DataW-1]}}, sf_i} + {{2{hs[DataW-1]}}, hs});

    side_d.conv    = conv;
    side_d.mode    = mode_i;
    side_d.sum_pos = sum_sat.val > 0;
    if (!conv) begin
      side_d.val0 = own_val_i;
      side_d.val1 = own_sig_i;
      side_d.clip = 1'b0;
    end else if (mode_i == MODE_ANOMALOUS) begin
      side_d.val0 = a_sat.val;
      side_d.val1 = s_sat.val;
      side_d.clip = a_sat.clip | s_sat.clip;
    end else begin
      side_d.val0 = own_val_i;
      side_d.val1 = own_sig_i;
      side_d.clip = (~v_pos & sp_sat.clip) | sum_sat.clip;
    end

    rad_f_d = {{(RadW-RawW){1'b0}}, mag, {FracBits{1'b0}}};
    rad_s_d = side_d.sum_pos
            ? {{(RadW-RawW){1'b0}}, sum_sat.val[DataW-1:0], {FracBits{1'b0}}}
            : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_f_q   <= rad_f_d;
      rad_s_q   <= rad_s_d;
      side_q[0] <= side_d;
    end
  end

  // side data rides along with the root stages
  for (genvar k = 1; k <= QW; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  rac_sqrt #(.RadW(RadW)) u_sqrt_amp (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .rad_i  (rad_f_q),
    .root_o (root_f)
  );

  rac_sqrt #(.RadW(RadW)) u_sqrt_sum (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .rad_i  (rad_s_q),
    .root_o (root_s)
  );

  always_comb begin
    side_o = side_q[QW];
    res_o.clip = side_o.clip;
    if (side_o.conv && side_o.mode == MODE_INTENSITY) begin
      res_o.amp       = {{(DataW-QW){1'b0}}, root_f};
      res_o.amp_sigma = side_o.sum_pos
                      ? ({{(DataW-QW){1'b0}}, root_s} - {{(DataW-QW){1'b0}}, root_f})
                      : '0;
    end else begin
      res_o.amp       = side_o.val0;
      res_o.amp_sigma = side_o.val1;
    end
  end

endmodule

/* rtl/reflection_amplitude_convert_core.sv */
// ----------------------------------------------------------------------------
// reflection_amplitude_convert_core
// Intensity to amplitude conversion, two pair lanes and a merge register.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_ready_o   in_data_i  (rac_in_t)
//   out       output     out_valid_o / out_ready_i out_data_o (rac_out_t)
//   cfg       input      cfg_we_i                  cfg_wdata_i (mode)
//
// one item per cycle unless the output stalls; each lane has an operand register and
// bit-per-stage square root pipelines, followed by the merge register.
// all stages advance together when the output register is empty or taken,
// so a stall at the output holds the whole pipeline.
// reset clears the valid chain and selects intensity mode.
// ----------------------------------------------------------------------------
module reflection_amplitude_convert_core #(
  parameter int unsigned FracBits = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rac_pkg::rac_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rac_pkg::rac_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i
);
  import rac_pkg::*;

  localparam int unsigned RawW = DataW + FracBits;
  localparam int unsigned RadW = RawW + (RawW % 2);
  localparam int unsigned QW   = RadW / 2;

  logic          mode_q;
  logic          en;
  logic [QW:0]   vld_q;
  logic          out_vld_q;
  rac_out_t      out_q, out_d;
  rac_lane_res_t res_p, res_m;

  assign en         = ~out_vld_q | out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_INTENSITY;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[QW-1:0], in_valid_i};
      out_vld_q <= vld_q[QW];
    end
  end

  rac_lane #(.FracBits(FracBits), .IsMinus(1'b0)) u_lane_plus (
    .clk_i     (clk_i),
    .en_i      (en),
    .mode_i    (mode_q),
    .own_val_i (in_data_i.value_plus),
    .own_sig_i (in_data_i.sigma_plus),
    .f_i       (in_data_i.value_plus),
    .sf_i      (in_data_i.sigma_plus),
    .d_i       (in_data_i.value_minus),
    .sd_i      (in_data_i.sigma_minus),
    .res_o     (res_p)
  );

  rac_lane #(.FracBits(FracBits), .IsMinus(1'b1)) u_lane_minus (
    .clk_i     (clk_i),
    .en_i      (en),
    .mode_i    (mode_q),
    .own_val_i (in_data_i.value_minus),
    .own_sig_i (in_data_i.sigma_minus),
    .f_i       (in_data_i.value_plus),
    .sf_i      (in_data_i.sigma_plus),
    .d_i       (in_data_i.value_minus),
    .sd_i      (in_data_i.sigma_minus),
    .res_o     (res_m)
  );

  // merge the two lanes
  always_comb begin
    out_d.amp_plus        = res_p.amp;
    out_d.amp_sigma_plus  = res_p.amp_sigma;
    out_d.amp_minus       = res_m.amp;
    out_d.amp_sigma_minus = res_m.amp_sigma;
    out_d.saturated       = res_p.clip | res_m.clip;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while output slot free");

  a_first_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vld_q[0]) |=> vld_q[1])
    else $error("item lost in pipeline");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(vld_q) && $stable(mode_q || !mode_q)))
    else $error("pipeline moved during stall");
`endif

endmodule
